@@ hw/rtl/boid_neighbour_accumulate_macros.svh @@
// ----------------------------------------------------------------------------
// Boid neighbour accumulate assertion macros
// Shared assertion helpers for the boid neighbour accumulate RTL.
// ----------------------------------------------------------------------------
`ifndef BOID_NEIGHBOUR_ACCUMULATE_MACROS_SVH
`define BOID_NEIGHBOUR_ACCUMULATE_MACROS_SVH

// Clocked check that is off while reset is applied.
`define BNA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is applied.
`define BNA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/bna_pkg.sv @@
// ----------------------------------------------------------------------------
// Boid neighbour accumulate package
// Types and constants shared by the boid neighbour accumulate modules.
// ----------------------------------------------------------------------------
package bna_pkg;

  // One stored boid: Q15.8 position and Q1.14 forward vector.
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
  } boid_t;

  // Widths of the difference, squared distance and quotient paths.
  localparam int unsigned DiffW = 25;
  localparam int unsigned Dist2W = 50;
  localparam int unsigned QuoW = 25;
  // Number of quotient bits the divider produces, one per cycle.
  localparam int unsigned DivSteps = 25;
  localparam int unsigned DivCntW = 5;

  // Divider request and status.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RSQ,
    S_RSQ_LAT,
    S_OWN_RD,
    S_OWN_LAT,
    S_OTH_RD,
    S_OTH_LAT,
    S_SQ,
    S_TEST,
    S_DIV_GO,
    S_DIV,
    S_EMIT
  } bna_state_e;

endpackage

@@ hw/rtl/boid_neighbour_accumulate.sv @@
// ----------------------------------------------------------------------------
// Boid neighbour accumulate
// Loads a set of boids, then emits per-boid neighbour count, heading sum,
// position sum and saturated avoidance sum, in load order.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                Payload
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_data_i (perception radius)
//   in       in         in_valid_i/in_stall_o    pos_*, fwd_*, last_boid
//   out      out        out_valid_o/out_stall_i  counts, sums, last_result
//
// Loading takes one boid per cycle. After the last boid, each boid is compared
// with every other through the shared squarer, and each perceived pair at
// nonzero distance also passes through the bit-serial divider.
// Reset clears the boid count and the radius; the boid store needs no clearing.
// A stalled result holds the sequencer; no request is taken until a set is out.
// ----------------------------------------------------------------------------
`include "boid_neighbour_accumulate_macros.svh"

module boid_neighbour_accumulate
  import bna_pkg::*;
#(
  parameter int unsigned MAX_BOIDS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic signed [15:0] fwd_x_i,
  input  logic signed [15:0] fwd_y_i,
  input  logic signed [15:0] fwd_z_i,
  input  logic               last_boid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         neighbour_count_o,
  output logic signed [21:0] dir_sum_x_o,
  output logic signed [21:0] dir_sum_y_o,
  output logic signed [21:0] dir_sum_z_o,
  output logic signed [29:0] center_sum_x_o,
  output logic signed [29:0] center_sum_y_o,
  output logic signed [29:0] center_sum_z_o,
  output logic signed [31:0] avoid_x_o,
  output logic signed [31:0] avoid_y_o,
  output logic signed [31:0] avoid_z_o,
  output logic               last_result_o
);

  localparam int unsigned AddrW = $clog2(MAX_BOIDS);
  localparam int unsigned CntW  = $clog2(MAX_BOIDS + 1);
  localparam int unsigned AccW  = 26 + $clog2(MAX_BOIDS);

  bna_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d;
  logic [1:0]  k_q, k_d;
  logic [15:0] radius_q;
  logic [31:0] rsq_q, rsq_d;
  logic [Dist2W-1:0] prod_q, prod_d, d2_q, d2_d;
  logic signed [23:0] own_x_q, own_y_q, own_z_q, own_x_d, own_y_d, own_z_d;
  boid_t oth_q, oth_d;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic [5:0] ncnt_q, ncnt_d;
  logic signed [21:0] dsx_q, dsy_q, dsz_q, dsx_d, dsy_d, dsz_d;
  logic signed [29:0] csx_q, csy_q, csz_q, csx_d, csy_d, csz_d;
  logic signed [AccW-1:0] avx_q, avy_q, avz_q, avx_d, avy_d, avz_d;

  logic in_acc, ram_we;
  boid_t wr_boid, rd_boid;
  logic [AddrW-1:0] raddr;
  logic signed [DiffW-1:0] mul_a, dsel;
  logic signed [Dist2W-1:0] mul_p;
  logic [DiffW-1:0] mag;
  logic signed [AccW-1:0] term;
  logic neighbour;
  div_ctl_t div_ctl;
  div_sts_t div_sts;
  logic [QuoW-1:0] quo;

  // Clamp a wide avoidance sum into 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi, lo;
    hi = $signed({{(AccW-31){1'b0}}, {31{1'b1}}});
    lo = $signed({{(AccW-31){1'b1}}, {31{1'b0}}});
    if (v > hi) begin
      sat32 = hi[31:0];
    end else if (v < lo) begin
      sat32 = lo[31:0];
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign ram_we      = in_acc && (cnt_q < CntW'(MAX_BOIDS));
  assign wr_boid     = '{pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i,
                         fwd_x: fwd_x_i, fwd_y: fwd_y_i, fwd_z: fwd_z_i};
  assign raddr       = (state_q == S_OWN_RD) ? i_q[AddrW-1:0] : j_q[AddrW-1:0];

  // Boid store.
  bna_ram #(
    .Width($bits(boid_t)),
    .Depth(MAX_BOIDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i(wr_boid),
    .raddr_i(raddr),
    .rdata_o(rd_boid)
  );

  // Shared squarer: the radius once per set, then one offset per cycle.
  always_comb begin
    case (k_q)
      2'd0:    dsel = dx_q;
      2'd1:    dsel = dy_q;
      default: dsel = dz_q;
    endcase
    mul_a = (state_q == S_RSQ) ? $signed({{(DiffW-16){1'b0}}, radius_q}) : dsel;
    mul_p = mul_a * mul_a;
    mag   = dsel[DiffW-1] ? DiffW'(-dsel) : DiffW'(dsel);
    term  = dsel[DiffW-1] ? $signed({{(AccW-QuoW){1'b0}}, quo})
                          : -$signed({{(AccW-QuoW){1'b0}}, quo});
    neighbour = (radius_q == '0) ||
                (d2_q < {{(Dist2W-48){1'b0}}, rsq_q, 16'b0});
  end

  bna_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (div_ctl),
    .mag_i (mag),
    .den_i (d2_q),
    .sts_o (div_sts),
    .quo_o (quo)
  );

  // Sequencer: next state, counters and accumulators.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;  n_d = n_q;  i_d = i_q;  j_d = j_q;  k_d = k_q;
    rsq_d = rsq_q;  prod_d = prod_q;  d2_d = d2_q;
    own_x_d = own_x_q;  own_y_d = own_y_q;  own_z_d = own_z_q;
    oth_d = oth_q;  dx_d = dx_q;  dy_d = dy_q;  dz_d = dz_q;
    ncnt_d = ncnt_q;
    dsx_d = dsx_q;  dsy_d = dsy_q;  dsz_d = dsz_q;
    csx_d = csx_q;  csy_d = csy_q;  csz_d = csz_q;
    avx_d = avx_q;  avy_d = avy_q;  avz_d = avz_q;
    div_ctl.start = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d = cnt_q + CntW'(ram_we);
          if (last_boid_i) begin
            n_d = cnt_d;
            state_d = S_RSQ;
          end
        end
      end
      S_RSQ: begin
        prod_d = Dist2W'(mul_p);
        state_d = S_RSQ_LAT;
      end
      S_RSQ_LAT: begin
        rsq_d = prod_q[31:0];
        i_d = '0;
        state_d = S_OWN_RD;
      end
      S_OWN_RD: begin
        state_d = S_OWN_LAT;
      end
      S_OWN_LAT: begin
        own_x_d = rd_boid.pos_x;
        own_y_d = rd_boid.pos_y;
        own_z_d = rd_boid.pos_z;
        ncnt_d = '0;
        dsx_d = '0;  dsy_d = '0;  dsz_d = '0;
        csx_d = '0;  csy_d = '0;  csz_d = '0;
        avx_d = '0;  avy_d = '0;  avz_d = '0;
        j_d = '0;
        state_d = S_OTH_RD;
      end
      S_OTH_RD: begin
        if (j_q == n_q) begin
          state_d = S_EMIT;
        end else if (j_q == i_q) begin
          j_d = j_q + 1'b1;
        end else begin
          state_d = S_OTH_LAT;
        end
      end
      S_OTH_LAT: begin
        oth_d = rd_boid;
        dx_d = DiffW'(rd_boid.pos_x) - DiffW'(own_x_q);
        dy_d = DiffW'(rd_boid.pos_y) - DiffW'(own_y_q);
        dz_d = DiffW'(rd_boid.pos_z) - DiffW'(own_z_q);
        j_d = j_q + 1'b1;
        d2_d = '0;
        k_d = '0;
        state_d = S_SQ;
      end
      S_SQ: begin
        // The product of one step is added in the next.
        if (k_q != 2'd3) begin
          prod_d = Dist2W'(mul_p);
        end
        if (k_q != 2'd0) begin
          d2_d = d2_q + prod_q;
        end
        if (k_q == 2'd3) begin
          k_d = '0;
          state_d = S_TEST;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_TEST: begin
        state_d = S_OTH_RD;
        if (neighbour) begin
          ncnt_d = ncnt_q + 1'b1;
          dsx_d = dsx_q + 22'(oth_q.fwd_x);
          dsy_d = dsy_q + 22'(oth_q.fwd_y);
          dsz_d = dsz_q + 22'(oth_q.fwd_z);
          csx_d = csx_q + 30'(oth_q.pos_x);
          csy_d = csy_q + 30'(oth_q.pos_y);
          csz_d = csz_q + 30'(oth_q.pos_z);
          // A coincident pair adds no avoidance.
          if (d2_q != '0) begin
            state_d = S_DIV_GO;
          end
        end
      end
      S_DIV_GO: begin
        div_ctl.start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) begin
          case (k_q)
            2'd0:    avx_d = avx_q + term;
            2'd1:    avy_d = avy_q + term;
            default: avz_d = avz_q + term;
          endcase
          if (k_q == 2'd2) begin
            k_d = '0;
            state_d = S_OTH_RD;
          end else begin
            k_d = k_q + 1'b1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (i_q + 1'b1 == n_q) begin
            cnt_d = '0;
            state_d = S_IDLE;
          end else begin
            i_d = i_q + 1'b1;
            state_d = S_OWN_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      n_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      radius_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rsq_q   <= rsq_d;
    prod_q  <= prod_d;
    d2_q    <= d2_d;
    own_x_q <= own_x_d;
    own_y_q <= own_y_d;
    own_z_q <= own_z_d;
    oth_q   <= oth_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    dz_q    <= dz_d;
    ncnt_q  <= ncnt_d;
    dsx_q   <= dsx_d;
    dsy_q   <= dsy_d;
    dsz_q   <= dsz_d;
    csx_q   <= csx_d;
    csy_q   <= csy_d;
    csz_q   <= csz_d;
    avx_q   <= avx_d;
    avy_q   <= avy_d;
    avz_q   <= avz_d;
  end

  // Result ports come straight from the accumulators.
  assign neighbour_count_o = ncnt_q;
  assign dir_sum_x_o    = dsx_q;
  assign dir_sum_y_o    = dsy_q;
  assign dir_sum_z_o    = dsz_q;
  assign center_sum_x_o = csx_q;
  assign center_sum_y_o = csy_q;
  assign center_sum_z_o = csz_q;
  assign avoid_x_o      = sat32(avx_q);
  assign avoid_y_o      = sat32(avy_q);
  assign avoid_z_o      = sat32(avz_q);
  assign last_result_o  = (i_q + 1'b1 == n_q);

  // No load request is taken while a result is on offer.
  `BNA_ASSERT_ALWAYS(a_emit_blocks_load, out_valid_o |-> in_stall_o, "load during emit")
  // The store fill never passes its depth.
  `BNA_ASSERT(a_cnt_bound, cnt_q <= CntW'(MAX_BOIDS), "boid count overflow")
  // Division is only requested for a nonzero squared distance.
  `BNA_ASSERT(a_div_nonzero, div_ctl.start |-> d2_q != '0, "division by zero distance")

endmodule

@@ hw/rtl/bna_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bna_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/bna_div.sv @@
// ----------------------------------------------------------------------------
// Avoidance divider
// Restoring divider computing (mag * 2^24) / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "boid_neighbour_accumulate_macros.svh"

module bna_div
  import bna_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_ctl_t          ctl_i,
  input  logic [DiffW-1:0]  mag_i,
  input  logic [Dist2W-1:0] den_i,
  output div_sts_t          sts_o,
  output logic [QuoW-1:0]   quo_o
);

  logic [Dist2W-1:0]  rem_q, rem_d;
  logic [Dist2W-1:0]  den_q, den_d;
  logic [QuoW-1:0]    shf_q, shf_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [Dist2W:0]    trial;

  // The quotient stays below 2^25, so the upper dividend bits form the
  // starting remainder and only the low 25 bits are shifted in.
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    shf_d  = shf_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, shf_q[QuoW-1]} - {1'b0, den_q};
    if (ctl_i.start) begin
      rem_d  = {{(Dist2W-DiffW+1){1'b0}}, mag_i[DiffW-1:1]};
      den_d  = den_i;
      shf_d  = {mag_i[0], {(QuoW-1){1'b0}}};
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[Dist2W]) begin
        rem_d = trial[Dist2W-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Dist2W-2:0], shf_q[QuoW-1]};
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      shf_d = {shf_q[QuoW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flags take reset; the datapath does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    shf_q <= shf_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

  // A new request never lands on a running division.
  `BNA_ASSERT(a_div_start_idle, ctl_i.start |-> !busy_q, "divider started while busy")
  // Completion is a single-cycle pulse that ends the busy phase.
  `BNA_ASSERT(a_div_done_pulse, done_q |-> !busy_q && $past(busy_q), "bad divider done")

endmodule
